### hdl/logistic_regression_scorer_top_defines.svh
// ----------------------------------------------------------------------------
// Logistic regression scorer assertion macros
// Shared concurrent assertion forms for the scorer RTL.
// ----------------------------------------------------------------------------
`ifndef LOGISTIC_REGRESSION_SCORER_TOP_DEFINES_SVH
`define LOGISTIC_REGRESSION_SCORER_TOP_DEFINES_SVH

// same-cycle implication
`define LRS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// Logistic regression scorer package
// Payload types, widths and register codes shared by the scorer modules.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int FEAT_MAX      = 4;
  localparam int N_FEATURES_DEF = 4;
  localparam int MAX_ITEMS_DEF  = 65536;
  localparam int SIG_DEPTH_DEF  = 1024;

  localparam int COEF_W      = 16;
  localparam int PROD_W      = 32;
  localparam int Z_W         = 35;
  localparam int PROB_W      = 16;
  localparam int METRIC_W    = 17;
  localparam int LOSS_W      = 36;
  localparam int SQ_W        = 49;
  localparam int SQ_ITEM_W   = 33;
  localparam int Q_W         = 17;
  localparam int LOSS_ITEM_W = 20;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [2:0] {
    CFG_COEF_INTERCEPT = 3'd0,
    CFG_COEF_0         = 3'd1,
    CFG_COEF_1         = 3'd2,
    CFG_COEF_2         = 3'd3,
    CFG_COEF_3         = 3'd4,
    CFG_USE_INTERCEPT  = 3'd5,
    CFG_LABELS_PRESENT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic               label;
    logic               last_item;
  } obs_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        predicted_class;
    logic        metrics_valid;
    logic [16:0] mean_sq_error;
    logic [35:0] log_loss_sum;
    logic [16:0] misclass_rate;
  } score_t;

endpackage

### hdl/lrs_lane.sv
// ----------------------------------------------------------------------------
// Scorer lane
// One coefficient times one feature, registered.
// ----------------------------------------------------------------------------
module lrs_lane import lrs_pkg::*; (
  input  logic                     clk,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [COEF_W-1:0] feature,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= coef * feature;
  end

endmodule

### hdl/lrs_merge.sv
// ----------------------------------------------------------------------------
// Scorer merge stage
// Sums the lane products and the intercept term into the Q19.16 score.
// ----------------------------------------------------------------------------
module lrs_merge import lrs_pkg::*; #(
  parameter int N_LANES = N_FEATURES_DEF
) (
  input  logic                     clk,
  input  logic signed [PROD_W-1:0] prods [N_LANES],
  input  logic signed [COEF_W-1:0] coef_intercept,
  input  logic                     use_intercept,
  output logic signed [Z_W-1:0]    z
);

  logic signed [Z_W-1:0] sum;

  always_comb begin
    sum = use_intercept ? (Z_W'(coef_intercept) <<< 8) : '0;
    for (int i = 0; i < N_LANES; i++) begin
      sum = sum + Z_W'(prods[i]);
    end
  end

  always_ff @(posedge clk) begin
    z <= sum;
  end

endmodule

### hdl/lrs_sigmoid.sv
// ----------------------------------------------------------------------------
// Scorer sigmoid table
// Constant Q0.16 sigmoid table over [-8, 8), registered read.
// ----------------------------------------------------------------------------
module lrs_sigmoid import lrs_pkg::*; #(
  parameter  int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF,
  localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  addr,
  output logic [PROB_W-1:0] prob
);

  typedef logic [PROB_W-1:0] rom_t [SIGMOID_TABLE_DEPTH];

  // shift-subtract quotient, evaluated only while building the table
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r, qt;
    r  = '0;
    qt = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r     = r - b;
        qt[i] = 1'b1;
      end
    end
    return qt;
  endfunction

  function automatic logic [PROB_W-1:0] sig_entry(input int idx);
    logic signed [63:0] d;
    logic [63:0] ad, g, term, e, den, p;
    d = $signed(64'(idx) * 64'd16) - $signed(64'(SIGMOID_TABLE_DEPTH) * 64'd8);
    if (d == 0) begin
      return 16'h8000;
    end
    ad   = (d < 0) ? 64'(-d) : 64'(d);
    g    = udiv(ad << 28, 64'(SIGMOID_TABLE_DEPTH));
    term = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * g) >> 32, 64'(k));
      if (k[0]) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      e = (e * e) >> 32;
    end
    den = (64'd1 << 32) + e;
    if (d > 0) begin
      p = udiv((64'd1 << 48) + (den >> 1), den);
    end else begin
      p = udiv((e << 16) + (den >> 1), den);
    end
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      r[i] = sig_entry(i);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    prob <= ROM[addr];
  end

endmodule

### hdl/lrs_log.sv
// ----------------------------------------------------------------------------
// Scorer log-loss unit
// Computes ln(65536/q) in Q16: log2 by repeated squaring, one bit per cycle,
// then a split multiply by ln2.
// ----------------------------------------------------------------------------
module lrs_log import lrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [Q_W-1:0]         q,
  output logic                   done,
  output logic [LOSS_ITEM_W-1:0] loss
);

  localparam int SQR_STEPS = 20;

  typedef enum logic [2:0] {L_IDLE, L_SQR, L_MULH, L_MULL, L_SUM} lstate_t;

  lstate_t     state;
  logic [4:0]  n, n_in;
  logic [31:0] m, m_in, m2;
  logic [63:0] sqr;
  logic [19:0] frac;
  logic [4:0]  cnt;
  logic [24:0] neg;
  logic [40:0] ph, pl;
  logic [56:0] total;

  always_comb begin
    n_in = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (q[i]) begin
        n_in = 5'(i);
      end
    end
    m_in  = 32'(q) << (5'd30 - n_in);
    sqr   = 64'(m) * 64'(m);
    m2    = sqr[61:30];
    neg   = 25'h100_0000 - {n, frac};
    total = {ph, 16'b0} + 57'(pl) + (57'd1 << 35);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == L_SUM);
      unique case (state)
        L_IDLE: begin
          if (start) begin
            n     <= n_in;
            m     <= m_in;
            frac  <= '0;
            cnt   <= '0;
            state <= L_SQR;
          end
        end
        L_SQR: begin
          if (m2[31]) begin
            m    <= m2 >> 1;
            frac <= {frac[18:0], 1'b1};
          end else begin
            m    <= m2;
            frac <= {frac[18:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(SQR_STEPS - 1)) begin
            state <= L_MULH;
          end
        end
        L_MULH: begin
          ph    <= 41'(neg) * 41'(LN2_Q32[31:16]);
          state <= L_MULL;
        end
        L_MULL: begin
          pl    <= 41'(neg) * 41'(LN2_Q32[15:0]);
          state <= L_SUM;
        end
        L_SUM: begin
          loss  <= total[55:36];
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

### hdl/lrs_div.sv
// ----------------------------------------------------------------------------
// Scorer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrs_div import lrs_pkg::*; #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  always_comb begin
    shifted = {rem, quotient[NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (!busy) begin
        if (start) begin
          rem      <= '0;
          quotient <= num;
          cnt      <= CNT_W'(NUM_W);
          busy     <= 1'b1;
        end
      end else begin
        rem      <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], ge};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hdl/logistic_regression_scorer_top.sv
// ----------------------------------------------------------------------------
// Logistic regression scorer
// Scores one observation at a time: lanes multiply features by coefficients,
// a merge stage sums them, a sigmoid table gives a Q0.16 probability.
// Usage: the obs channel carries one observation per transfer; the score
// channel returns one result per observation, in order. Both use valid/stall.
// Write coefficients and flags through cfg_we/cfg_index/cfg_data while idle.
// Pace: a new observation is taken only after the result of the last one has
// gone to the output register. With labels_present high the log-loss unit
// (20 squaring steps) sets the pace; the last item of a set with labels adds
// two divisions in the shared divider, DIV_W = 34 at default sizes.
// Reset clears the totals, sets use_intercept, clears labels_present and
// the coefficients. A stalled result holds in the output register while the
// next observation is already taken; the block then waits before the output.
// ----------------------------------------------------------------------------
`include "logistic_regression_scorer_top_defines.svh"

module logistic_regression_scorer_top import lrs_pkg::*; #(
  parameter int N_FEATURES          = N_FEATURES_DEF,
  parameter int MAX_ITEMS           = MAX_ITEMS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        obs_valid,
  output logic        obs_stall,
  input  obs_t        obs_data,
  output logic        score_valid,
  input  logic        score_stall,
  output score_t      score_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N_LANES     = (N_FEATURES < FEAT_MAX) ? N_FEATURES : FEAT_MAX;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W       = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int IP_W        = 21 + IDX_W;
  localparam int MSE_NUM_W   = SQ_W - 15;
  localparam int RATE_NUM_W  = CNT_W + 17;
  localparam int DIV_W       = (RATE_NUM_W > MSE_NUM_W) ? RATE_NUM_W : MSE_NUM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LANE, ST_SUM, ST_IDX, ST_LUT, ST_PROB, ST_SQ, ST_LOG,
    ST_ACC, ST_MSE_GO, ST_MSE_WAIT, ST_RATE_GO, ST_RATE_WAIT, ST_OUT
  } state_t;

  state_t                    state;
  obs_t                      item;
  logic signed [COEF_W-1:0]  coefs [5];
  logic                      use_intercept;
  logic                      labels_present;

  logic signed [COEF_W-1:0]  feats [FEAT_MAX];
  logic signed [PROD_W-1:0]  prods [N_LANES];
  logic signed [Z_W-1:0]     z;
  logic [19:0]               z_off;
  logic [IP_W-1:0]           idx_prod;
  logic [IDX_W-1:0]          idx;
  logic                      sat_hi, sat_lo;
  logic [PROB_W-1:0]         rom_prob, p, p_next;
  logic [Q_W-1:0]            mag, q;
  logic [SQ_ITEM_W-1:0]      sq;

  logic                      log_start, log_done;
  logic [LOSS_ITEM_W-1:0]    loss_item;

  logic [SQ_W-1:0]           sq_err_total, sq_next;
  logic [LOSS_W-1:0]         loss_total, loss_next;
  logic [CNT_W-1:0]          miss_count, item_count;
  logic [SQ_W:0]             sq_sum, mse_num;
  logic [LOSS_W:0]           loss_sum;
  logic [RATE_NUM_W-1:0]     rate_num;
  logic [METRIC_W-1:0]       mse_q, rate_q, quo_cap;

  logic                      div_start, div_done;
  logic [DIV_W-1:0]          div_num, div_quo;
  logic                      rpt;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        coefs[i] <= '0;
      end
      use_intercept  <= 1'b1;
      labels_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [CFG_COEF_INTERCEPT:CFG_COEF_3]: coefs[cfg_index] <= cfg_data;
        CFG_USE_INTERCEPT:               use_intercept <= cfg_data[0];
        CFG_LABELS_PRESENT:              labels_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lanes and merge
  always_comb begin
    feats[0] = item.feature_0;
    feats[1] = item.feature_1;
    feats[2] = item.feature_2;
    feats[3] = item.feature_3;
  end

  for (genvar i = 0; i < N_LANES; i++) begin : g_lane
    lrs_lane u_lane (
      .clk     (clk),
      .coef    (coefs[i+1]),
      .feature (feats[i]),
      .prod    (prods[i])
    );
  end

  lrs_merge #(.N_LANES(N_LANES)) u_merge (
    .clk            (clk),
    .prods          (prods),
    .coef_intercept (coefs[0]),
    .use_intercept  (use_intercept),
    .z              (z)
  );

  lrs_sigmoid #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_sigmoid (
    .clk  (clk),
    .addr (idx),
    .prob (rom_prob)
  );

  lrs_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .q     (q),
    .done  (log_done),
    .loss  (loss_item)
  );

  lrs_div #(.NUM_W(DIV_W), .DEN_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (item_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    z_off    = 20'(z + 35'sd524288);
    idx_prod = IP_W'(z_off) * IP_W'(SIGMOID_TABLE_DEPTH);
    p_next   = sat_hi ? 16'hFFFF : (sat_lo ? 16'h0000 : rom_prob);
    mag      = item.label ? (17'h10000 - 17'(p)) : 17'(p);
    q        = item.label ? 17'(p) : (17'h10000 - 17'(p));
    if (q == '0) begin
      q = 17'd1;
    end
    log_start = (state == ST_SQ) && labels_present;

    sq_sum    = {1'b0, sq_err_total} + (SQ_W+1)'(sq);
    sq_next   = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    loss_sum  = {1'b0, loss_total} + (LOSS_W+1)'(loss_item);
    loss_next = loss_sum[LOSS_W] ? '1 : loss_sum[LOSS_W-1:0];

    mse_num   = {1'b0, sq_err_total} + ((SQ_W+1)'(item_count) << 15);
    rate_num  = (RATE_NUM_W'(miss_count) << 16) + RATE_NUM_W'(item_count >> 1);
    div_start = (state == ST_MSE_GO) || (state == ST_RATE_GO);
    div_num   = (state == ST_MSE_GO) ? DIV_W'(mse_num[SQ_W:16]) : DIV_W'(rate_num);
    quo_cap   = (div_quo > DIV_W'(65536)) ? 17'h10000 : div_quo[METRIC_W-1:0];
    rpt       = item.last_item && labels_present;
  end

  assign obs_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      score_valid  <= 1'b0;
      sq_err_total <= '0;
      loss_total   <= '0;
      miss_count   <= '0;
      item_count   <= '0;
    end else begin
      if (score_valid && !score_stall && (state != ST_OUT)) begin
        score_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (obs_valid) begin
            item  <= obs_data;
            state <= ST_LANE;
          end
        end
        ST_LANE: state <= ST_SUM;
        ST_SUM:  state <= ST_IDX;
        ST_IDX: begin
          idx    <= idx_prod[20 +: IDX_W];
          sat_hi <= (z >= 35'sd524288);
          sat_lo <= (z < -35'sd524288);
          state  <= ST_LUT;
        end
        ST_LUT: state <= ST_PROB;
        ST_PROB: begin
          p     <= p_next;
          state <= ST_SQ;
        end
        ST_SQ: begin
          sq    <= SQ_ITEM_W'(34'(mag) * 34'(mag));
          state <= labels_present ? ST_LOG : ST_ACC;
        end
        ST_LOG: begin
          if (log_done) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (item_count < CNT_W'(MAX_ITEMS)) begin
            item_count <= item_count + CNT_W'(1);
          end
          if (labels_present) begin
            sq_err_total <= sq_next;
            loss_total   <= loss_next;
            if ((p[15] != item.label) && (miss_count < CNT_W'(MAX_ITEMS))) begin
              miss_count <= miss_count + CNT_W'(1);
            end
          end
          state <= rpt ? ST_MSE_GO : ST_OUT;
        end
        ST_MSE_GO: state <= ST_MSE_WAIT;
        ST_MSE_WAIT: begin
          if (div_done) begin
            mse_q <= quo_cap;
            state <= ST_RATE_GO;
          end
        end
        ST_RATE_GO: state <= ST_RATE_WAIT;
        ST_RATE_WAIT: begin
          if (div_done) begin
            rate_q <= quo_cap;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!score_valid || !score_stall) begin
            score_data.probability     <= p;
            score_data.predicted_class <= p[15];
            score_data.metrics_valid   <= item.last_item;
            score_data.mean_sq_error   <= rpt ? mse_q : '0;
            score_data.log_loss_sum    <= rpt ? loss_total : '0;
            score_data.misclass_rate   <= rpt ? rate_q : '0;
            score_valid                <= 1'b1;
            if (item.last_item) begin
              sq_err_total <= '0;
              loss_total   <= '0;
              miss_count   <= '0;
              item_count   <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LRS_ASSERT_NXT(a_busy_after_transfer, clk, rst, obs_valid && !obs_stall, obs_stall,
                  "obs channel not stalled after transfer")
  `LRS_ASSERT_IMP(a_metrics_gated, clk, rst, score_valid && !score_data.metrics_valid,
                  score_data.mean_sq_error == '0 && score_data.log_loss_sum == '0
                  && score_data.misclass_rate == '0,
                  "metrics nonzero on a non-final result")
  `LRS_ASSERT_IMP(a_class_rounding, clk, rst, score_valid,
                  score_data.predicted_class == score_data.probability[15],
                  "class does not match probability")
  `LRS_ASSERT_IMP(a_count_bounds, clk, rst, 1'b1,
                  item_count <= CNT_W'(MAX_ITEMS) && miss_count <= item_count,
                  "item or miss count out of range")

endmodule
